@@ rtl/qslp_pkg.sv @@
`default_nettype none

package qslp_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;

    // internal Q.30 datapath
    localparam int CW        = 34;
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 30;

    localparam logic [30:0]          ONE30    = 31'h4000_0000;
    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;

    // floor(atan(2^-i) * 2^30)
    function automatic logic signed [CW-1:0] atan_lut(input int i);
        logic signed [CW-1:0] v;
        case (i)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd7;
            28: v = 34'sd3;
            29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/quaternion_slerp_top.sv @@
// Channel   | Direction | Signals                                   | Handshake
// request   | in        | i_q0_*, i_q1_*, i_blend                   | start, busy
// result    | out       | o_out_w, o_out_x, o_out_y, o_out_z        | o_valid strobe
// config    | in        | i_cfg_data (near threshold)               | i_cfg_valid, o_cfg_ready
//
// One request per cycle; busy stays low and the pipeline never stops.
// o_valid pulses once the request has passed r_v1 to r_v4, the r_vd chain and r_valid.
// The depth is set by the 31-stage square root, two 16-stage CORDIC chains
// and the 30-stage divider, one bit or step per stage.
// Synchronous active-low reset clears the valid bits and loads the default threshold.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none

module quaternion_slerp_top import qslp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_q0_w,
    input  logic [15:0] i_q0_x,
    input  logic [15:0] i_q0_y,
    input  logic [15:0] i_q0_z,
    input  logic [15:0] i_q1_w,
    input  logic [15:0] i_q1_x,
    input  logic [15:0] i_q1_y,
    input  logic [15:0] i_q1_z,
    input  logic [15:0] i_blend,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_out_w,
    output logic [15:0] o_out_x,
    output logic [15:0] o_out_y,
    output logic [15:0] o_out_z
);

    localparam logic [14:0] THR_RST = 15'd16382;
    localparam int          C30_SH  = 30 - 2 * FRAC_BITS;
    localparam logic [15:0] ONE_Q   = 16'(1 << FRAC_BITS);
    localparam logic [61:0] SQ_TOP  = 62'h1000_0000_0000_0000;

    // pipeline levels counted from the side-line entry
    localparam int LV_SQ   = SQ_STEPS;
    localparam int LV_ANG  = LV_SQ + CORDIC_STEPS;
    localparam int LV_MUL  = LV_ANG + 1;
    localparam int LV_SIN  = LV_MUL + CORDIC_STEPS;
    localparam int LV_DIV  = LV_SIN + DIV_STEPS;
    localparam int LV_PRD  = LV_DIV + 1;
    localparam int SD_LEN  = LV_PRD + 1;
    localparam int SP_LEN  = LV_DIV - LV_SQ;
    localparam int SP_SIN  = LV_SIN - LV_SQ - 1;
    localparam int SP_DIV  = LV_DIV - LV_SQ - 1;
    localparam int LATENCY = LV_PRD + 6;

    typedef struct packed {
        logic [3:0][15:0] q0;
        logic [3:0][16:0] q1n;
        logic [29:0]      t30;
        logic [30:0]      c30;
        logic             tlo;
        logic             thi;
        logic             neg;
        logic             near;
    } t_side;

    typedef struct packed {
        logic [30:0] s;
        logic        sph;
    } t_sph;

    logic [14:0] r_thr;

    logic                    r_v1, r_v2, r_v3, r_v4;
    logic                    r_vd [SD_LEN];
    logic                    r_valid;

    logic [3:0][15:0]        r_q0_1, r_q1_1, r_q0_2, r_q1_2, r_q0_3, r_q1_3;
    logic [15:0]             r_t1, r_t2, r_t3;
    logic signed [31:0]      r_p2 [4];
    logic signed [33:0]      r_dot3;
    t_side                   n_side, r_side4;
    t_side                   r_sd [SD_LEN];
    logic [61:0]             r_csq;

    logic [61:0]             r_sq_rad  [SQ_STEPS];
    logic [32:0]             r_sq_rem  [SQ_STEPS];
    logic [30:0]             r_sq_root [SQ_STEPS];

    logic signed [CW-1:0]    r_an_x [CORDIC_STEPS];
    logic signed [CW-1:0]    r_an_y [CORDIC_STEPS];
    logic signed [CW-1:0]    r_an_z [CORDIC_STEPS];

    t_sph                    r_sp [SP_LEN];
    logic [30:0]             r_a0, r_a1;
    logic [30:0]             sin0, sin1, kd0, kd1;

    logic signed [47:0]      r_p0 [4];
    logic signed [47:0]      r_p1 [4];
    logic [15:0]             r_out [4];

    logic                    neg4;
    logic [33:0]             abs4;
    logic [30:0]             s_root;
    logic signed [CW-1:0]    z_ang;
    logic [30:0]             omega;
    logic [60:0]             m_a1;
    logic [61:0]             m_a0;
    logic [30:0]             k0, k1;
    t_side                   sd_div, sd_prd;
    t_sph                    sp_div;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RST;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_valid <= 1'b0;
            for (int k = 0; k < SD_LEN; k++) begin
                r_vd[k] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            r_v1    <= start && !busy;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_vd[0] <= r_v4;
            for (int k = 1; k < SD_LEN; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_valid <= r_vd[SD_LEN-1];
        end
    end

    // front end: capture, dot product, sign fold
    assign neg4 = r_dot3[33];
    assign abs4 = neg4 ? -r_dot3 : r_dot3;

    always_comb begin
        n_side     = '0;
        n_side.q0  = r_q0_3;
        n_side.neg = neg4;
        for (int i = 0; i < 4; i++) begin
            n_side.q1n[i] = neg4 ? -17'($signed(r_q1_3[i])) : 17'($signed(r_q1_3[i]));
        end
        n_side.tlo  = $signed(r_t3) <= 16'sd0;
        n_side.thi  = $signed(r_t3) >= $signed(ONE_Q);
        n_side.t30  = 30'(r_t3[FRAC_BITS-1:0]) << (30 - FRAC_BITS);
        n_side.near = abs4[32:0] > (33'(r_thr) << FRAC_BITS);
        n_side.c30  = (abs4[32:0] > 33'(ONE30 >> C30_SH)) ? ONE30 : 31'(abs4 << C30_SH);
    end

    always_ff @(posedge i_clk) begin
        r_q0_1 <= {i_q0_z, i_q0_y, i_q0_x, i_q0_w};
        r_q1_1 <= {i_q1_z, i_q1_y, i_q1_x, i_q1_w};
        r_t1   <= i_blend;
        r_q0_2 <= r_q0_1;
        r_q1_2 <= r_q1_1;
        r_t2   <= r_t1;
        for (int i = 0; i < 4; i++) begin
            r_p2[i] <= $signed(r_q0_1[i]) * $signed(r_q1_1[i]);
        end
        r_q0_3  <= r_q0_2;
        r_q1_3  <= r_q1_2;
        r_t3    <= r_t2;
        r_dot3  <= 34'(r_p2[0]) + 34'(r_p2[1]) + 34'(r_p2[2]) + 34'(r_p2[3]);
        r_side4 <= n_side;
        r_sd[0] <= r_side4;
        r_csq   <= 62'(r_side4.c30) * 62'(r_side4.c30);
        for (int k = 1; k < SD_LEN; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // integer square root of 1 - c^2, two radicand bits per stage
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        logic [61:0] rad_in;
        logic [32:0] rem_in;
        logic [30:0] root_in;
        logic [34:0] acc, trial;
        if (j == 0) begin : g_first
            assign rad_in  = SQ_TOP - r_csq;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_sq_rad[j-1];
            assign rem_in  = r_sq_rem[j-1];
            assign root_in = r_sq_root[j-1];
        end
        assign acc   = {rem_in, rad_in[61:60]};
        assign trial = {2'b00, root_in, 2'b01};
        always_ff @(posedge i_clk) begin
            r_sq_rad[j] <= {rad_in[59:0], 2'b00};
            if (acc >= trial) begin
                r_sq_rem[j]  <= 33'(acc - trial);
                r_sq_root[j] <= {root_in[29:0], 1'b1};
            end else begin
                r_sq_rem[j]  <= 33'(acc);
                r_sq_root[j] <= {root_in[29:0], 1'b0};
            end
        end
    end

    assign s_root = r_sq_root[SQ_STEPS-1];

    // angle of (c, s) by CORDIC vectoring
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_ang
        logic signed [CW-1:0] xi, yi, zi;
        if (i == 0) begin : g_first
            assign xi = CW'(r_sd[LV_SQ].c30);
            assign yi = CW'(s_root);
            assign zi = '0;
        end else begin : g_next
            assign xi = r_an_x[i-1];
            assign yi = r_an_y[i-1];
            assign zi = r_an_z[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (!yi[CW-1] && yi != '0) begin
                r_an_x[i] <= xi + (yi >>> i);
                r_an_y[i] <= yi - (xi >>> i);
                r_an_z[i] <= zi + atan_lut(i);
            end else begin
                r_an_x[i] <= xi - (yi >>> i);
                r_an_y[i] <= yi + (xi >>> i);
                r_an_z[i] <= zi - atan_lut(i);
            end
        end
    end

    // sine of omega and the spherical flag ride alongside
    always_ff @(posedge i_clk) begin
        r_sp[0].s   <= s_root;
        r_sp[0].sph <= !r_sd[LV_SQ].near && (s_root != '0);
        for (int k = 1; k < SP_LEN; k++) begin
            r_sp[k] <= r_sp[k-1];
        end
    end

    // split omega by t
    assign z_ang = r_an_z[CORDIC_STEPS-1];
    assign omega = z_ang[CW-1] ? '0 : z_ang[30:0];
    assign m_a1  = 61'(r_sd[LV_ANG].t30) * 61'(omega);
    assign m_a0  = 62'(ONE30 - 31'(r_sd[LV_ANG].t30)) * 62'(omega);

    always_ff @(posedge i_clk) begin
        r_a1 <= 31'(m_a1 >> 30);
        r_a0 <= 31'(m_a0 >> 30);
    end

    qslp_sin u_sin0 (
        .i_clk (i_clk),
        .i_ang (CW'(r_a0)),
        .o_sin (sin0)
    );

    qslp_sin u_sin1 (
        .i_clk (i_clk),
        .i_ang (CW'(r_a1)),
        .o_sin (sin1)
    );

    qslp_div u_div0 (
        .i_clk (i_clk),
        .i_num (sin0),
        .i_den (r_sp[SP_SIN].s),
        .o_quo (kd0)
    );

    qslp_div u_div1 (
        .i_clk (i_clk),
        .i_num (sin1),
        .i_den (r_sp[SP_SIN].s),
        .o_quo (kd1)
    );

    // weights times components
    assign sd_div = r_sd[LV_DIV];
    assign sp_div = r_sp[SP_DIV];
    assign k0     = sp_div.sph ? kd0 : ONE30 - 31'(sd_div.t30);
    assign k1     = sp_div.sph ? kd1 : 31'(sd_div.t30);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_p0[i] <= $signed({1'b0, k0}) * $signed(sd_div.q0[i]);
            r_p1[i] <= $signed({1'b0, k1}) * $signed(sd_div.q1n[i]);
        end
    end

    // round, saturate, pick the end points for t outside 0..1
    assign sd_prd = r_sd[LV_PRD];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            logic signed [47:0] sum;
            logic signed [47:0] sh;
            sum = r_p0[i] + r_p1[i] + 48'sh2000_0000;
            sh  = sum >>> 30;
            if (sd_prd.tlo) begin
                r_out[i] <= sd_prd.q0[i];
            end else if (sd_prd.thi) begin
                r_out[i] <= 16'(sd_prd.neg ? -sd_prd.q1n[i] : sd_prd.q1n[i]);
            end else if (sh > 48'sd32767) begin
                r_out[i] <= 16'h7fff;
            end else if (sh < -48'sd32768) begin
                r_out[i] <= 16'h8000;
            end else begin
                r_out[i] <= sh[15:0];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_out_w = r_out[0];
    assign o_out_x = r_out[1];
    assign o_out_y = r_out[2];
    assign o_out_z = r_out[3];

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("request did not produce a result");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    a_sph_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd[LV_DIV] && sp_div.sph) |-> !sd_div.near)
        else $error("spherical weights chosen above the near threshold");

endmodule

`default_nettype wire

@@ rtl/qslp_sin.sv @@
`default_nettype none

module qslp_sin import qslp_pkg::*; (
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_ang,
    output logic [30:0]          o_sin
);

    logic signed [CW-1:0] r_x [CORDIC_STEPS];
    logic signed [CW-1:0] r_y [CORDIC_STEPS];
    logic signed [CW-1:0] r_z [CORDIC_STEPS];
    logic signed [CW-1:0] y_last;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic signed [CW-1:0] xi, yi, zi;
        if (i == 0) begin : g_first
            assign xi = GAIN_INV;
            assign yi = '0;
            assign zi = i_ang;
        end else begin : g_next
            assign xi = r_x[i-1];
            assign yi = r_y[i-1];
            assign zi = r_z[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (!zi[CW-1]) begin
                r_x[i] <= xi - (yi >>> i);
                r_y[i] <= yi + (xi >>> i);
                r_z[i] <= zi - atan_lut(i);
            end else begin
                r_x[i] <= xi + (yi >>> i);
                r_y[i] <= yi - (xi >>> i);
                r_z[i] <= zi + atan_lut(i);
            end
        end
    end

    assign y_last = r_y[CORDIC_STEPS-1];

    // clamp to 0..one
    always_comb begin
        if (y_last[CW-1]) begin
            o_sin = '0;
        end else if (y_last > $signed(CW'(ONE30))) begin
            o_sin = ONE30;
        end else begin
            o_sin = y_last[30:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/qslp_div.sv @@
`default_nettype none

module qslp_div import qslp_pkg::*; (
    input  logic        i_clk,
    input  logic [30:0] i_num,
    input  logic [30:0] i_den,
    output logic [30:0] o_quo
);

    logic [31:0]          r_rem [DIV_STEPS];
    logic [30:0]          r_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS];
    logic                 r_ge  [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
        logic [31:0]          rem_in;
        logic [31:0]          rem2;
        logic [30:0]          den_in;
        logic [DIV_STEPS-1:0] quo_in;
        logic                 ge_in;
        if (j == 0) begin : g_first
            assign rem_in = 32'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
            // quotient of one or more saturates
            assign ge_in  = (i_num >= i_den);
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign quo_in = r_quo[j-1];
            assign ge_in  = r_ge[j-1];
        end
        assign rem2 = {rem_in[30:0], 1'b0};
        always_ff @(posedge i_clk) begin
            r_den[j] <= den_in;
            r_ge[j]  <= ge_in;
            if (rem2 >= 32'(den_in)) begin
                r_rem[j] <= rem2 - 32'(den_in);
                r_quo[j] <= {quo_in[DIV_STEPS-2:0], 1'b1};
            end else begin
                r_rem[j] <= rem2;
                r_quo[j] <= {quo_in[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    assign o_quo = r_ge[DIV_STEPS-1] ? ONE30 : 31'(r_quo[DIV_STEPS-1]);

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import qslp_pkg::*;

    localparam int LATENCY   = 101;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1630;

    typedef struct packed {
        logic signed [15:0] q0w, q0x, q0y, q0z;
        logic signed [15:0] q1w, q1x, q1y, q1z;
        logic signed [15:0] t;
    } slerp_req_t;

    typedef struct packed {
        logic signed [15:0] w, x, y, z;
    } quat_t;

    typedef struct {
        slerp_req_t req;
        bit         has_exp;
        quat_t      exp_q;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_q0_w = '0, i_q0_x = '0, i_q0_y = '0, i_q0_z = '0;
    logic [15:0] i_q1_w = '0, i_q1_x = '0, i_q1_y = '0, i_q1_z = '0;
    logic [15:0] i_blend = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_data = '0;
    logic        o_valid;
    logic [15:0] o_out_w, o_out_x, o_out_y, o_out_z;

    quaternion_slerp_top dut (.*);

    always #4 i_clk = ~i_clk;

    logic [14:0] near_thr;
    quat_t       pending_q[$];
    int          n_fail = 0;
    int          idle_cycles = 0;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint arctan_step(int i);
        longint tab[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127, 63, 31, 15, 7, 3, 1};
        return (i < 30) ? tab[i] : 0;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, nx, ny;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z += arctan_step(i);
            end else begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z -= arctan_step(i);
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint rotate_sine(longint z);
        longint x, y, nx, ny;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z -= arctan_step(i);
            end else begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z += arctan_step(i);
            end
            x = nx;
            y = ny;
        end
        if (y < 0) y = 0;
        if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
        return y;
    endfunction

    function automatic longint arc_weight(longint sn, longint s);
        longint unsigned k;
        k = (longint'(sn) << 30) / s;
        if (k > (64'd1 << 30)) k = 64'd1 << 30;
        return longint'(k);
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic quat_t slerp_predict(slerp_req_t r, logic [14:0] thr);
        longint a[4], b[4], res[4];
        longint t, dot, c30, s, k0, k1, t30, omega, a0, a1;
        quat_t q;
        t = r.t;
        a = '{r.q0w, r.q0x, r.q0y, r.q0z};
        b = '{r.q1w, r.q1x, r.q1y, r.q1z};
        if (t <= 0) begin
            res = a;
        end else if (t >= (1 << FRAC_BITS)) begin
            res = b;
        end else begin
            dot = 0;
            for (int i = 0; i < 4; i++) dot += a[i] * b[i];
            if (dot < 0) begin
                dot = -dot;
                for (int i = 0; i < 4; i++) b[i] = -b[i];
            end
            t30 = t << (30 - FRAC_BITS);
            k0 = (64'sd1 << 30) - t30;
            k1 = t30;
            if (dot <= (longint'(thr) << FRAC_BITS)) begin
                c30 = dot << (30 - 2 * FRAC_BITS);
                if (c30 > (64'sd1 << 30)) c30 = 64'sd1 << 30;
                s = int_sqrt((64'd1 << 60) - longint'(c30) * longint'(c30));
                if (s > 0) begin
                    omega = vector_angle(c30, s);
                    if (omega < 0) omega = 0;
                    a1 = (t30 * omega) >>> 30;
                    a0 = (((64'sd1 << 30) - t30) * omega) >>> 30;
                    k0 = arc_weight(rotate_sine(a0), s);
                    k1 = arc_weight(rotate_sine(a1), s);
                end
            end
            for (int i = 0; i < 4; i++)
                res[i] = floor_shr(k0 * a[i] + k1 * b[i] + (64'sd1 << 29), 30);
        end
        q.w = sat16(res[0]);
        q.x = sat16(res[1]);
        q.y = sat16(res[2]);
        q.z = sat16(res[3]);
        return q;
    endfunction

    // check results as they come out
    always @(posedge i_clk) begin
        quat_t e;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result %h %h %h %h", o_out_w, o_out_x, o_out_y, o_out_z);
                n_fail++;
            end else begin
                e = pending_q.pop_front();
                if (o_out_w !== e.w) begin
                    $error("out_w exp %h got %h", e.w, o_out_w); n_fail++;
                end
                if (o_out_x !== e.x) begin
                    $error("out_x exp %h got %h", e.x, o_out_x); n_fail++;
                end
                if (o_out_y !== e.y) begin
                    $error("out_y exp %h got %h", e.y, o_out_y); n_fail++;
                end
                if (o_out_z !== e.z) begin
                    $error("out_z exp %h got %h", e.z, o_out_z); n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_request(slerp_req_t r, bit has_exp, quat_t given);
        quat_t p;
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // drop start only for a real gap, so back-to-back requests keep it high
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_q0_w  <= r.q0w; i_q0_x <= r.q0x; i_q0_y <= r.q0y; i_q0_z <= r.q0z;
        i_q1_w  <= r.q1w; i_q1_x <= r.q1x; i_q1_y <= r.q1y; i_q1_z <= r.q1z;
        i_blend <= r.t;
        do @(posedge i_clk); while (busy);
        p = slerp_predict(r, near_thr);
        if (has_exp && p !== given) begin
            $error("table row disagrees with predictor: %h vs %h", given, p);
            n_fail++;
        end
        pending_q.push_back(p);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [14:0] v);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        near_thr = v;
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic slerp_req_t rand_request();
        slerp_req_t r;
        int mode;
        r = {rand_comp(), rand_comp(), rand_comp(), rand_comp(),
             rand_comp(), rand_comp(), rand_comp(), rand_comp(), 16'sd0};
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            // close pair, near-linear path
            r.q1w = r.q0w + 16'($urandom_range(0, 8)) - 16'sd4;
            r.q1x = r.q0x; r.q1y = r.q0y;
            r.q1z = r.q0z + 16'($urandom_range(0, 8)) - 16'sd4;
        end
        case ($urandom_range(0, 9))
            0: r.t = 16'($urandom);
            1: r.t = 16'($urandom_range(0, 1)) ? 16'sd0 : 16'sd16384;
            default: r.t = 16'($urandom_range(1, 16383));
        endcase
        return r;
    endfunction

    stim_row_t rows[$];

    initial begin
        slerp_req_t r;
        stim_row_t  row;
        near_thr = 15'd16382;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // t clamps: copy q0 or q1 straight through
        rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
            16'sh1234, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000}, 1,
            '{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff}});
        rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
            16'sh1234, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh8000}, 1,
            '{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff}});
        rows.push_back('{'{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
            16'sh1234, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh4000}, 1,
            '{16'sh1234, 16'sh8000, 16'sh7fff, 16'sh0000}});
        rows.push_back('{'{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
            16'shc000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff}, 1,
            '{16'shc000, 16'sh0000, 16'sh0000, 16'sh0000}});
        // identical unit quaternions: degenerate angle, linear weights
        rows.push_back('{'{16'sh4000, 16'sh0, 16'sh0, 16'sh0,
            16'sh4000, 16'sh0, 16'sh0, 16'sh0, 16'sh2000}, 1,
            '{16'sh4000, 16'sh0, 16'sh0, 16'sh0}});
        // orthogonal, opposite (negative dot), oversized, saturating
        rows.push_back('{'{16'sh4000, 16'sh0, 16'sh0, 16'sh0,
            16'sh0, 16'sh4000, 16'sh0, 16'sh0, 16'sh2000}, 0, '0});
        rows.push_back('{'{16'sh4000, 16'sh0, 16'sh0, 16'sh0,
            16'shd000, 16'sh2000, 16'sh0, 16'sh0, 16'sh1000}, 0, '0});
        rows.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
            16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh2000}, 0, '0});
        rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
            16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0001}, 0, '0});
        rows.push_back('{'{16'sh2d41, 16'sh2d41, 16'sh0, 16'sh0,
            16'sh2d41, 16'shd2bf, 16'sh0, 16'sh0, 16'sh3fff}, 0, '0});
        rows.push_back('{'{16'sh4000, 16'sh0, 16'sh0, 16'sh0,
            16'sh3fff, 16'sh0100, 16'sh0, 16'sh0, 16'sh2000}, 0, '0});
        rows.push_back('{'{16'sh0, 16'sh0, 16'sh0, 16'sh0,
            16'sh0, 16'sh0, 16'sh0, 16'sh0, 16'sh2000}, 0, '0});

        foreach (rows[i]) send_request(rows[i].req, rows[i].has_exp, rows[i].exp_q);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_threshold(15'd0);
                1: write_threshold(15'd16384);
                2: write_threshold(15'h7fff);
                3: write_threshold(15'($urandom_range(14000, 16384)));
                default: write_threshold(15'd16382);
            endcase
            // pause until the pipeline is empty at least once per phase
            send_request('{16'sh4000, 16'sh0, 16'sh0, 16'sh0,
                16'sh3ff0, 16'sh0200, 16'sh0, 16'sh0, 16'sh2000}, 0, '0);
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                r = rand_request();
                if ($urandom_range(0, 3) == 0) begin
                    // back-to-back burst with no idle gap
                    start <= 1'b1;
                    i_q0_w <= r.q0w; i_q0_x <= r.q0x; i_q0_y <= r.q0y; i_q0_z <= r.q0z;
                    i_q1_w <= r.q1w; i_q1_x <= r.q1x; i_q1_y <= r.q1y; i_q1_z <= r.q1z;
                    i_blend <= r.t;
                    do @(posedge i_clk); while (busy);
                    pending_q.push_back(slerp_predict(r, near_thr));
                end else begin
                    send_request(r, 0, '0);
                end
            end
        end

        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
